// ----- src/vpb_pkg.sv -----
// Shared types, register codes and reset values for the particle bounce block.
package vpb_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_PARTICLES_DEF = 8;
    localparam int POS_WIDTH_DEF     = 20;

    // Fixed field widths
    localparam int IN_POS_W = 20;
    localparam int SLOT_W   = 3;
    localparam int PIX_W    = 12;
    localparam int GRAV_W   = 13;
    localparam int WALL_W   = 11;
    localparam int RAD_W    = 8;
    localparam int COEF_W   = 16;
    localparam int CNT_W    = 4;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    // Register reset values
    localparam logic [COEF_W-1:0]        FRICTION_RST = 16'd65470;
    localparam logic [COEF_W-1:0]        BOUNCE_RST   = 16'd58982;
    localparam logic signed [GRAV_W-1:0] GRAVITY_RST  = 13'sd253;
    localparam logic [WALL_W-1:0]        NEAR_RST     = 11'd50;
    localparam logic [WALL_W-1:0]        RIGHT_RST    = 11'd1029;
    localparam logic [WALL_W-1:0]        BOTTOM_RST   = 11'd669;
    localparam logic [RAD_W-1:0]         RADIUS_RST   = 8'd10;
    localparam logic [CNT_W-1:0]         COUNT_RST    = 4'd2;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_FRICTION    = 3'd0,
        REG_BOUNCE      = 3'd1,
        REG_GRAVITY     = 3'd2,
        REG_NEAR_WALL   = 3'd3,
        REG_RIGHT_WALL  = 3'd4,
        REG_BOTTOM_WALL = 3'd5,
        REG_RADIUS      = 3'd6,
        REG_COUNT       = 3'd7
    } reg_idx_t;

    // Item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic [COEF_W-1:0]        friction;
        logic [COEF_W-1:0]        bounce;
        logic signed [GRAV_W-1:0] gravity;
        logic [WALL_W-1:0]        near_wall;
        logic [WALL_W-1:0]        right_wall;
        logic [WALL_W-1:0]        bottom_wall;
        logic [RAD_W-1:0]         ball_radius;
        logic [CNT_W-1:0]         active_count;
    } cfg_t;

    // Sequencer states: one particle takes READ through STORE
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_LATCH,
        ST_VEL_X,
        ST_ADV_X,
        ST_ADV_Y,
        ST_BNC_X,
        ST_OLD_X,
        ST_BNC_Y,
        ST_OLD_Y,
        ST_STORE
    } state_t;

    // Multiplier operand selects
    typedef enum logic [1:0] {
        MUL_A_DX,
        MUL_A_DY,
        MUL_A_VEL
    } mul_a_t;

    typedef enum logic {
        MUL_B_FRICTION,
        MUL_B_BOUNCE
    } mul_b_t;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic   load;
        logic   rd;
        logic   latch;
        logic   mul_en;
        mul_a_t mul_a;
        mul_b_t mul_b;
        logic   adv_x;
        logic   adv_y;
        logic   clamp;
        logic   axis_y;
        logic   old_upd;
        logic   store;
    } dp_cmd_t;

endpackage

// ----- src/verlet_particle_bounce_step.sv -----
// Top level of the Verlet particle step with wall bounce.
//
// A load item (kind 0) writes one slot of the particle table in the cycle it is
// accepted and leaves busy low, so items may follow back to back. A tick item
// (kind 1) walks slots 0 to active_count-1 (clipped to the table size) and holds
// busy high while it steps each particle through states READ to STORE. The one
// shared signed multiplier (POS_WIDTH+1 by 17 bits) is used six times per
// particle, beside the table read and the write-back on separate RAM ports. Each
// particle gives one result beat on result_valid for exactly one cycle, the last
// one of the tick marked by last; the receiver cannot stall, so results must be
// taken as they come. A tick with an active count of zero gives no results.
// Configuration must be written over APB only while busy is low and no result is
// pending; the block itself does not enforce this.
module verlet_particle_bounce_step #(
    parameter int MAX_PARTICLES = vpb_pkg::MAX_PARTICLES_DEF,
    parameter int POS_WIDTH     = vpb_pkg::POS_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   kind,
    input  logic [vpb_pkg::SLOT_W-1:0]             slot,
    input  logic signed [vpb_pkg::IN_POS_W-1:0]    pos_x,
    input  logic signed [vpb_pkg::IN_POS_W-1:0]    pos_y,
    input  logic signed [vpb_pkg::IN_POS_W-1:0]    prev_x,
    input  logic signed [vpb_pkg::IN_POS_W-1:0]    prev_y,
    output logic                                   result_valid,
    output logic [vpb_pkg::SLOT_W-1:0]             out_slot,
    output logic signed [vpb_pkg::PIX_W-1:0]       draw_x,
    output logic signed [vpb_pkg::PIX_W-1:0]       draw_y,
    output logic                                   last,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [vpb_pkg::APB_AW-1:0]             paddr,
    input  logic [vpb_pkg::APB_DW-1:0]             pwdata,
    output logic [vpb_pkg::APB_DW-1:0]             prdata,
    output logic                                   pready
);

    import vpb_pkg::*;

    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

    cfg_t          cfg;
    dp_cmd_t       cmd;
    logic [AW-1:0] idx;
    logic          idx_last;

    vpb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vpb_ctrl #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .kind         (kind),
        .active_count (cfg.active_count),
        .busy         (busy),
        .cmd          (cmd),
        .idx          (idx),
        .last         (idx_last)
    );

    vpb_dp #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .POS_WIDTH     (POS_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .idx          (idx),
        .last_in      (idx_last),
        .cfg          (cfg),
        .slot         (slot),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .prev_x       (prev_x),
        .prev_y       (prev_y),
        .result_valid (result_valid),
        .out_slot     (out_slot),
        .draw_x       (draw_x),
        .draw_y       (draw_y),
        .last         (last)
    );

endmodule

// ----- src/vpb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module vpb_ram #(
    parameter  int WIDTH = 80,
    parameter  int DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/vpb_regs.sv -----
// APB configuration register bank for the particle bounce block.
module vpb_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vpb_pkg::APB_AW-1:0]  paddr,
    input  logic [vpb_pkg::APB_DW-1:0]  pwdata,
    output logic [vpb_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output vpb_pkg::cfg_t               cfg
);

    import vpb_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Decode a write beat into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_FRICTION:    cfg_next.friction     = pwdata[COEF_W-1:0];
                REG_BOUNCE:      cfg_next.bounce       = pwdata[COEF_W-1:0];
                REG_GRAVITY:     cfg_next.gravity      = $signed(pwdata[GRAV_W-1:0]);
                REG_NEAR_WALL:   cfg_next.near_wall    = pwdata[WALL_W-1:0];
                REG_RIGHT_WALL:  cfg_next.right_wall   = pwdata[WALL_W-1:0];
                REG_BOTTOM_WALL: cfg_next.bottom_wall  = pwdata[WALL_W-1:0];
                REG_RADIUS:      cfg_next.ball_radius  = pwdata[RAD_W-1:0];
                REG_COUNT:       cfg_next.active_count = pwdata[CNT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.friction     <= FRICTION_RST;
            cfg_reg.bounce       <= BOUNCE_RST;
            cfg_reg.gravity      <= GRAVITY_RST;
            cfg_reg.near_wall    <= NEAR_RST;
            cfg_reg.right_wall   <= RIGHT_RST;
            cfg_reg.bottom_wall  <= BOTTOM_RST;
            cfg_reg.ball_radius  <= RADIUS_RST;
            cfg_reg.active_count <= COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (idx)
            REG_FRICTION:    prdata = APB_DW'(cfg_reg.friction);
            REG_BOUNCE:      prdata = APB_DW'(cfg_reg.bounce);
            REG_GRAVITY:     prdata = APB_DW'($unsigned(cfg_reg.gravity));
            REG_NEAR_WALL:   prdata = APB_DW'(cfg_reg.near_wall);
            REG_RIGHT_WALL:  prdata = APB_DW'(cfg_reg.right_wall);
            REG_BOTTOM_WALL: prdata = APB_DW'(cfg_reg.bottom_wall);
            REG_RADIUS:      prdata = APB_DW'(cfg_reg.ball_radius);
            REG_COUNT:       prdata = APB_DW'(cfg_reg.active_count);
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/vpb_ctrl.sv -----
// Sequencer that walks the particle slots and steps the datapath for each one.
module vpb_ctrl #(
    parameter  int MAX_PARTICLES = vpb_pkg::MAX_PARTICLES_DEF,
    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          kind,
    input  logic [vpb_pkg::CNT_W-1:0]     active_count,
    output logic                          busy,
    output vpb_pkg::dp_cmd_t              cmd,
    output logic [AW-1:0]                 idx,
    output logic                          last
);

    import vpb_pkg::*;

    localparam int CW = AW + 1;
    localparam int NW = (CW > CNT_W) ? CW : CNT_W;

    state_t        state_reg;
    state_t        state_next;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] n_next;
    logic [NW-1:0] count_w;
    logic [NW-1:0] n_lim;
    logic [CW-1:0] idx_inc;

    // Clip the slot count to the table size
    assign count_w = NW'(active_count);
    assign n_lim   = (count_w > NW'(MAX_PARTICLES)) ? NW'(MAX_PARTICLES) : count_w;
    assign idx_inc = idx_reg + CW'(1);
    assign last    = (idx_inc == n_reg);
    assign idx     = idx_reg[AW-1:0];
    assign busy    = (state_reg != ST_IDLE);

    // Next state and slot counter
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && kind == KIND_TICK)
                begin
                    n_next   = n_lim[CW-1:0];
                    idx_next = '0;
                    if (n_lim != '0)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:  state_next = ST_LATCH;
            ST_LATCH: state_next = ST_VEL_X;
            ST_VEL_X: state_next = ST_ADV_X;
            ST_ADV_X: state_next = ST_ADV_Y;
            ST_ADV_Y: state_next = ST_BNC_X;
            ST_BNC_X: state_next = ST_OLD_X;
            ST_OLD_X: state_next = ST_BNC_Y;
            ST_BNC_Y: state_next = ST_OLD_Y;
            ST_OLD_Y: state_next = ST_STORE;
            ST_STORE:
            begin
                idx_next   = idx_inc;
                state_next = last ? ST_IDLE : ST_READ;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
        end
    end

    // Datapath commands for each step
    always_comb
    begin
        cmd       = '0;
        cmd.mul_a = MUL_A_DX;
        cmd.mul_b = MUL_B_FRICTION;
        unique case (state_reg)
            ST_IDLE:  cmd.load = start && (kind == KIND_LOAD);
            ST_READ:  cmd.rd = 1'b1;
            ST_LATCH: cmd.latch = 1'b1;
            ST_VEL_X:
            begin
                cmd.mul_en = 1'b1;
            end
            ST_ADV_X:
            begin
                cmd.adv_x  = 1'b1;
                cmd.mul_en = 1'b1;
                cmd.mul_a  = MUL_A_DY;
            end
            ST_ADV_Y:
            begin
                cmd.adv_y  = 1'b1;
                cmd.mul_en = 1'b1;
            end
            ST_BNC_X:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_a  = MUL_A_VEL;
                cmd.mul_b  = MUL_B_BOUNCE;
                cmd.clamp  = 1'b1;
            end
            ST_OLD_X:
            begin
                cmd.old_upd = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_a   = MUL_A_DY;
            end
            ST_BNC_Y:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_a  = MUL_A_VEL;
                cmd.mul_b  = MUL_B_BOUNCE;
                cmd.clamp  = 1'b1;
                cmd.axis_y = 1'b1;
            end
            ST_OLD_Y:
            begin
                cmd.old_upd = 1'b1;
                cmd.axis_y  = 1'b1;
            end
            ST_STORE: cmd.store = 1'b1;
            default:  cmd.rd = 1'b0;
        endcase
    end

endmodule

// ----- src/vpb_dp.sv -----
// Datapath: particle table, shared multiplier, wall clamp and result registers.
module vpb_dp #(
    parameter  int MAX_PARTICLES = vpb_pkg::MAX_PARTICLES_DEF,
    parameter  int POS_WIDTH     = vpb_pkg::POS_WIDTH_DEF,
    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  vpb_pkg::dp_cmd_t                       cmd,
    input  logic [AW-1:0]                          idx,
    input  logic                                   last_in,
    input  vpb_pkg::cfg_t                          cfg,
    input  logic [vpb_pkg::SLOT_W-1:0]             slot,
    input  logic signed [vpb_pkg::IN_POS_W-1:0]    pos_x,
    input  logic signed [vpb_pkg::IN_POS_W-1:0]    pos_y,
    input  logic signed [vpb_pkg::IN_POS_W-1:0]    prev_x,
    input  logic signed [vpb_pkg::IN_POS_W-1:0]    prev_y,
    output logic                                   result_valid,
    output logic [vpb_pkg::SLOT_W-1:0]             out_slot,
    output logic signed [vpb_pkg::PIX_W-1:0]       draw_x,
    output logic signed [vpb_pkg::PIX_W-1:0]       draw_y,
    output logic                                   last
);

    import vpb_pkg::*;

    localparam int PW  = POS_WIDTH;
    localparam int VW  = PW + 1;
    localparam int PRW = VW + COEF_W + 1;
    localparam int WW  = ((PW > 22) ? PW : 22) + 4;
    localparam int SLW = ((AW + 1) > SLOT_W) ? (AW + 1) : SLOT_W;
    localparam int RW  = 4 * PW;

    localparam logic signed [WW-1:0] POS_MAX = {{(WW-PW+1){1'b0}}, {(PW-1){1'b1}}};
    localparam logic signed [WW-1:0] POS_MIN = ~POS_MAX;
    localparam logic signed [WW-1:0] PIX_MAX = WW'(2047);
    localparam logic signed [WW-1:0] PIX_MIN = WW'(-2048);
    localparam logic signed [WW-1:0] RND     = WW'(255);

    // Saturate a wide value to the position range
    function automatic logic signed [PW-1:0] sat_pos(input logic signed [WW-1:0] v);
        logic signed [PW-1:0] r;
        if (v > POS_MAX)
        begin
            r = POS_MAX[PW-1:0];
        end
        else if (v < POS_MIN)
        begin
            r = POS_MIN[PW-1:0];
        end
        else
        begin
            r = v[PW-1:0];
        end
        return r;
    endfunction

    // Whole pixels, truncated toward zero, saturated to the draw range
    function automatic logic signed [PIX_W-1:0] to_pix(input logic signed [PW-1:0] v);
        logic signed [WW-1:0] w;
        logic signed [WW-1:0] t;
        logic signed [PIX_W-1:0] r;
        w = WW'(v);
        if (w < 0)
        begin
            t = (w + RND) >>> 8;
        end
        else
        begin
            t = w >>> 8;
        end
        if (t > PIX_MAX)
        begin
            r = PIX_MAX[PIX_W-1:0];
        end
        else if (t < PIX_MIN)
        begin
            r = PIX_MIN[PIX_W-1:0];
        end
        else
        begin
            r = t[PIX_W-1:0];
        end
        return r;
    endfunction

    logic signed [PW-1:0]    x_reg, x_next;
    logic signed [PW-1:0]    y_reg, y_next;
    logic signed [PW-1:0]    ox_reg, ox_next;
    logic signed [PW-1:0]    oy_reg, oy_next;
    logic signed [VW-1:0]    prod_reg, prod_next;
    logic                    hit_reg, hit_next;
    logic                    valid_reg, valid_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic signed [PIX_W-1:0] dx_reg, dx_next;
    logic signed [PIX_W-1:0] dy_reg, dy_next;
    logic                    last_reg, last_next;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [RW-1:0]           ram_wdata;
    logic [RW-1:0]           ram_rdata;
    logic [SLW-1:0]          slot_w;
    logic                    slot_ok;

    logic signed [VW-1:0]    mul_a_val;
    logic signed [COEF_W:0]  mul_b_val;
    logic signed [PRW-1:0]   product;

    logic signed [PW-1:0]    axis_pos;
    logic [WALL_W-1:0]       far_wall;
    logic signed [WW-1:0]    far_q;
    logic signed [WW-1:0]    near_q;
    logic signed [WW-1:0]    rad_q;
    logic                    hit_hi;
    logic                    hit_lo;
    logic signed [PW-1:0]    clamp_pos;
    logic signed [PW-1:0]    old_val;

    // Particle table: {x, y, old x, old y} per slot
    vpb_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_PARTICLES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd),
        .raddr (idx),
        .rdata (ram_rdata)
    );

    // Load beats and tick write-back share the write port
    assign slot_w  = SLW'(slot);
    assign slot_ok = (slot_w < SLW'(MAX_PARTICLES));

    always_comb
    begin
        ram_we    = cmd.store | (cmd.load & slot_ok);
        ram_waddr = idx;
        ram_wdata = {x_reg, y_reg, ox_reg, oy_reg};
        if (cmd.load)
        begin
            ram_waddr = slot_w[AW-1:0];
            ram_wdata = {sat_pos(WW'(pos_x)), sat_pos(WW'(pos_y)),
                         sat_pos(WW'(prev_x)), sat_pos(WW'(prev_y))};
        end
    end

    // Shared multiplier, floor shift by 16
    always_comb
    begin
        case (cmd.mul_a)
            MUL_A_DX:  mul_a_val = VW'(x_reg) - VW'(ox_reg);
            MUL_A_DY:  mul_a_val = VW'(y_reg) - VW'(oy_reg);
            MUL_A_VEL: mul_a_val = prod_reg;
            default:   mul_a_val = prod_reg;
        endcase
        case (cmd.mul_b)
            MUL_B_FRICTION: mul_b_val = $signed({1'b0, cfg.friction});
            MUL_B_BOUNCE:   mul_b_val = $signed({1'b0, cfg.bounce});
            default:        mul_b_val = $signed({1'b0, cfg.friction});
        endcase
    end

    assign product = PRW'(mul_a_val) * PRW'(mul_b_val);

    // Wall test on the selected axis
    assign axis_pos = cmd.axis_y ? y_reg : x_reg;
    assign far_wall = cmd.axis_y ? cfg.bottom_wall : cfg.right_wall;
    assign far_q    = WW'({far_wall, 8'h00});
    assign near_q   = WW'({cfg.near_wall, 8'h00});
    assign rad_q    = WW'({cfg.ball_radius, 8'h00});
    assign hit_hi   = (WW'(axis_pos) > far_q);
    assign hit_lo   = (WW'(axis_pos) < near_q);
    assign clamp_pos = hit_hi ? sat_pos(far_q - rad_q) : sat_pos(near_q + rad_q);
    assign old_val   = sat_pos(WW'(axis_pos) + WW'(prod_reg));

    // Step the particle registers
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        ox_next   = ox_reg;
        oy_next   = oy_reg;
        prod_next = prod_reg;
        hit_next  = hit_reg;
        if (cmd.latch)
        begin
            {x_next, y_next, ox_next, oy_next} = ram_rdata;
        end
        if (cmd.mul_en)
        begin
            prod_next = product[PW+COEF_W:COEF_W];
        end
        if (cmd.adv_x)
        begin
            ox_next = x_reg;
            x_next  = sat_pos(WW'(x_reg) + WW'(prod_reg));
        end
        if (cmd.adv_y)
        begin
            oy_next = y_reg;
            y_next  = sat_pos(WW'(y_reg) + WW'(prod_reg) + WW'(cfg.gravity));
        end
        if (cmd.clamp)
        begin
            hit_next = hit_hi | hit_lo;
            if (hit_hi || hit_lo)
            begin
                if (cmd.axis_y)
                begin
                    y_next = clamp_pos;
                end
                else
                begin
                    x_next = clamp_pos;
                end
            end
        end
        if (cmd.old_upd && hit_reg)
        begin
            if (cmd.axis_y)
            begin
                oy_next = old_val;
            end
            else
            begin
                ox_next = old_val;
            end
        end
    end

    // Result beat
    always_comb
    begin
        valid_next = cmd.store;
        slot_next  = slot_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        last_next  = last_reg;
        if (cmd.store)
        begin
            slot_next = SLOT_W'(idx);
            dx_next   = to_pix(x_reg);
            dy_next   = to_pix(y_reg);
            last_next = last_in;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        prod_reg <= prod_next;
        hit_reg  <= hit_next;
        slot_reg <= slot_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign result_valid = valid_reg;
    assign out_slot     = slot_reg;
    assign draw_x       = dx_reg;
    assign draw_y       = dy_reg;
    assign last         = last_reg;

endmodule

// ----- src/vpb_checker.sv -----
// Port-level assertions for the particle bounce block, bound to the top level.
module vpb_checker (
    input logic clk,
    input logic rst_n,
    input logic busy,
    input logic result_valid,
    input logic last
);

    // A result beat always follows a busy cycle
    a_beat_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result beat without a running tick");

    // Beats of successive particles are never in adjacent cycles
    a_beat_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result beats in adjacent cycles");

    // A non-final beat leaves the tick running
    a_mid_beat_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("tick ended before its final beat");

    // The tick ends exactly on its final beat
    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid && last)
        else $error("busy dropped without a final beat");

    // The final beat leaves the block free for the next item
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> !busy)
        else $error("still busy after the final beat");

endmodule

bind verlet_particle_bounce_step vpb_checker u_vpb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .result_valid (result_valid),
    .last         (last)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Testbench for verlet_particle_bounce_step: directed and random items, checked by a scoreboard.
module tb;
    import vpb_pkg::*;

    localparam int     TABLE_DEPTH = MAX_PARTICLES_DEF;
    localparam longint POS_MAX     = (longint'(1) <<< (POS_WIDTH_DEF - 1)) - 1;
    localparam longint POS_MIN     = -POS_MAX - 1;
    localparam int     PHASES      = 10;
    localparam int     PHASE_ITEMS = 43;

    // One draw beat as the block reports it
    typedef struct {
        logic [SLOT_W-1:0]       slot;
        logic signed [PIX_W-1:0] x;
        logic signed [PIX_W-1:0] y;
        logic                    tail;
    } draw_beat_t;

    // Particle table, register copy and queue of expected draw beats
    class particle_scoreboard;
        logic [COEF_W-1:0]        friction;
        logic [COEF_W-1:0]        bounce;
        logic signed [GRAV_W-1:0] gravity;
        logic [WALL_W-1:0]        near_wall;
        logic [WALL_W-1:0]        right_wall;
        logic [WALL_W-1:0]        bottom_wall;
        logic [RAD_W-1:0]         ball_radius;
        logic [CNT_W-1:0]         active_count;
        longint                   cur_x[TABLE_DEPTH];
        longint                   cur_y[TABLE_DEPTH];
        longint                   old_x[TABLE_DEPTH];
        longint                   old_y[TABLE_DEPTH];
        draw_beat_t               draw_expected[$];
        int                       errors;

        function new();
            friction     = FRICTION_RST;
            bounce       = BOUNCE_RST;
            gravity      = GRAVITY_RST;
            near_wall    = NEAR_RST;
            right_wall   = RIGHT_RST;
            bottom_wall  = BOTTOM_RST;
            ball_radius  = RADIUS_RST;
            active_count = COUNT_RST;
            errors       = 0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                cur_x[i] = 0;
                cur_y[i] = 0;
                old_x[i] = 0;
                old_y[i] = 0;
            end
        endfunction

        function void set_reg(reg_idx_t idx, logic [APB_DW-1:0] v);
            case (idx)
                REG_FRICTION:    friction     = v[COEF_W-1:0];
                REG_BOUNCE:      bounce       = v[COEF_W-1:0];
                REG_GRAVITY:     gravity      = v[GRAV_W-1:0];
                REG_NEAR_WALL:   near_wall    = v[WALL_W-1:0];
                REG_RIGHT_WALL:  right_wall   = v[WALL_W-1:0];
                REG_BOTTOM_WALL: bottom_wall  = v[WALL_W-1:0];
                REG_RADIUS:      ball_radius  = v[RAD_W-1:0];
                REG_COUNT:       active_count = v[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return draw_expected.size();
        endfunction

        function longint sat_pos(longint v);
            if (v > POS_MAX)
                return POS_MAX;
            if (v < POS_MIN)
                return POS_MIN;
            return v;
        endfunction

        // Multiply by an unsigned Q0.16 factor, floor the result
        function longint scale_q16(longint v, logic [COEF_W-1:0] k);
            return (v * longint'(k)) >>> 16;
        endfunction

        // Whole pixels, truncated toward zero
        function logic signed [PIX_W-1:0] to_pix(longint v);
            longint p;
            p = (v >= 0) ? (v >>> 8) : -((-v) >>> 8);
            if (p > 2047)
                p = 2047;
            if (p < -2048)
                p = -2048;
            return p[PIX_W-1:0];
        endfunction

        // Push a position back inside the walls and set the rebound
        function void hit_wall(inout longint p, inout longint o, input longint vel,
                               input logic [WALL_W-1:0] far_wall);
            longint far_q;
            longint near_q;
            far_q  = longint'(far_wall) * 256;
            near_q = longint'(near_wall) * 256;
            if (p > far_q)
            begin
                p = sat_pos((longint'(far_wall) - longint'(ball_radius)) * 256);
                o = sat_pos(p + scale_q16(vel, bounce));
            end
            else if (p < near_q)
            begin
                p = sat_pos((longint'(near_wall) + longint'(ball_radius)) * 256);
                o = sat_pos(p + scale_q16(vel, bounce));
            end
        endfunction

        // Update the table for one accepted item, queue the draw beats of a tick
        function void take_item(logic k, logic [SLOT_W-1:0] s,
                                logic signed [IN_POS_W-1:0] px, logic signed [IN_POS_W-1:0] py,
                                logic signed [IN_POS_W-1:0] qx, logic signed [IN_POS_W-1:0] qy);
            int         n;
            longint     x, y, ox, oy, vx, vy;
            draw_beat_t b;
            if (k == KIND_LOAD)
            begin
                if (s < TABLE_DEPTH)
                begin
                    cur_x[s] = sat_pos(longint'(px));
                    cur_y[s] = sat_pos(longint'(py));
                    old_x[s] = sat_pos(longint'(qx));
                    old_y[s] = sat_pos(longint'(qy));
                end
                return;
            end
            n = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_count);
            for (int i = 0; i < n; i++)
            begin
                x  = cur_x[i];
                y  = cur_y[i];
                ox = old_x[i];
                oy = old_y[i];
                vx = scale_q16(x - ox, friction);
                vy = scale_q16(y - oy, friction);
                ox = x;
                oy = y;
                x  = sat_pos(x + vx);
                y  = sat_pos(y + vy + longint'(gravity));
                vx = scale_q16(x - ox, friction);
                vy = scale_q16(y - oy, friction);
                hit_wall(x, ox, vx, right_wall);
                hit_wall(y, oy, vy, bottom_wall);
                cur_x[i] = x;
                cur_y[i] = y;
                old_x[i] = ox;
                old_y[i] = oy;
                b.slot = SLOT_W'(i);
                b.x    = to_pix(x);
                b.y    = to_pix(y);
                b.tail = (i == n - 1);
                draw_expected.insert(draw_expected.size(), b);
            end
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR %0t: %s", $time, msg);
        endtask

        // Compare one draw beat with the oldest expectation
        task check_beat(logic [SLOT_W-1:0] s, logic signed [PIX_W-1:0] dx,
                        logic signed [PIX_W-1:0] dy, logic t);
            draw_beat_t e;
            if (draw_expected.size() == 0)
            begin
                report($sformatf("unexpected beat slot=%0d x=%0d y=%0d last=%0b", s, dx, dy, t));
                return;
            end
            e = draw_expected.pop_front();
            if (e.slot !== s || e.x !== dx || e.y !== dy || e.tail !== t)
                report($sformatf("beat got slot=%0d x=%0d y=%0d last=%0b, want %0d %0d %0d %0b",
                                 s, dx, dy, t, e.slot, e.x, e.y, e.tail));
        endtask

        task flag_leftover();
            while (draw_expected.size() != 0)
            begin
                report($sformatf("missing beat for slot %0d", draw_expected[0].slot));
                void'(draw_expected.pop_front());
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic kind = KIND_LOAD;
    logic [SLOT_W-1:0] slot = '0;
    logic signed [IN_POS_W-1:0] pos_x = '0;
    logic signed [IN_POS_W-1:0] pos_y = '0;
    logic signed [IN_POS_W-1:0] prev_x = '0;
    logic signed [IN_POS_W-1:0] prev_y = '0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic busy;
    logic result_valid;
    logic [SLOT_W-1:0] out_slot;
    logic signed [PIX_W-1:0] draw_x;
    logic signed [PIX_W-1:0] draw_y;
    logic last;
    logic [APB_DW-1:0] prdata;
    logic pready;
    logic no_gaps = 1'b0;

    particle_scoreboard sb = new();

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    verlet_particle_bounce_step i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .slot         (slot),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .prev_x       (prev_x),
        .prev_y       (prev_y),
        .result_valid (result_valid),
        .out_slot     (out_slot),
        .draw_x       (draw_x),
        .draw_y       (draw_y),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Take every draw beat at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
            sb.check_beat(out_slot, draw_x, draw_y, last);
    end

    // Hold one item until accepted, then draw an idle gap
    task automatic send(logic k, logic [SLOT_W-1:0] s,
                        logic signed [IN_POS_W-1:0] px, logic signed [IN_POS_W-1:0] py,
                        logic signed [IN_POS_W-1:0] qx, logic signed [IN_POS_W-1:0] qy);
        int gap;
        start  <= 1'b1;
        kind   <= k;
        slot   <= s;
        pos_x  <= px;
        pos_y  <= py;
        prev_x <= qx;
        prev_y <= qy;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.take_item(k, s, px, py, qx, qy);
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Tick with junk in the ignored load fields
    task automatic tick();
        send(KIND_TICK, SLOT_W'($urandom()), IN_POS_W'($urandom()), IN_POS_W'($urandom()),
             IN_POS_W'($urandom()), IN_POS_W'($urandom()));
    endtask

    function automatic logic signed [IN_POS_W-1:0] clip_pos(int v);
        if (v > POS_MAX)
            return IN_POS_W'(POS_MAX);
        if (v < POS_MIN)
            return IN_POS_W'(POS_MIN);
        return IN_POS_W'(v);
    endfunction

    // Mostly particles inside the window with modest speed, some raw noise
    task automatic random_load();
        int px, py;
        if ($urandom_range(0, 3) == 0)
        begin
            send(KIND_LOAD, SLOT_W'($urandom()), IN_POS_W'($urandom()), IN_POS_W'($urandom()),
                 IN_POS_W'($urandom()), IN_POS_W'($urandom()));
        end
        else
        begin
            px = int'($urandom_range(0, 524287));
            py = int'($urandom_range(0, 524287));
            send(KIND_LOAD, SLOT_W'($urandom_range(0, 7)), clip_pos(px), clip_pos(py),
                 clip_pos(px + int'($urandom_range(0, 4000)) - 2000),
                 clip_pos(py + int'($urandom_range(0, 4000)) - 2000));
        end
    endtask

    task automatic cfg_write(reg_idx_t idx, logic [APB_DW-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        sb.set_reg(idx, v);
    endtask

    task automatic write_all(int f, int b, int g, int nw, int rw, int bw, int r, int c);
        cfg_write(REG_FRICTION, f);
        cfg_write(REG_BOUNCE, b);
        cfg_write(REG_GRAVITY, g);
        cfg_write(REG_NEAR_WALL, nw);
        cfg_write(REG_RIGHT_WALL, rw);
        cfg_write(REG_BOTTOM_WALL, bw);
        cfg_write(REG_RADIUS, r);
        cfg_write(REG_COUNT, c);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drop start, wait for all beats and for busy to fall, then let the block sit idle
    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic hold_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Extreme of the range now and then, else a value that keeps particles moving
    function automatic int pick(int lo, int hi, int typ_lo, int typ_hi);
        case ($urandom_range(0, 5))
            0: return lo;
            1: return hi;
            default: return int'($urandom_range(typ_lo, typ_hi));
        endcase
    endfunction

    task automatic pick_config();
        write_all(pick(0, 65535, 60000, 65535), pick(0, 65535, 20000, 65535),
                  pick(0, 8191, 3796, 4696) - 4096, pick(0, 2047, 0, 200),
                  pick(0, 2047, 600, 2047), pick(0, 2047, 400, 2047),
                  pick(0, 255, 0, 40), pick(0, 15, 1, 8));
    endtask

    initial
    begin
        int w;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: two slots, extreme speeds and a corner at zero
        send(KIND_LOAD, 3'd0, 20'h7FFFF, 20'h80000, 20'h80000, 20'h7FFFF);
        send(KIND_LOAD, 3'd1, 20'h00000, 20'h00000, 20'h00000, 20'h00000);
        tick();

        // Full table: each wall, at rest, tiny negatives, exactly on a wall
        drain();
        write_all(int'(FRICTION_RST), int'(BOUNCE_RST), int'(GRAVITY_RST), int'(NEAR_RST),
                  int'(RIGHT_RST), int'(BOTTOM_RST), int'(RADIUS_RST), TABLE_DEPTH);
        send(KIND_LOAD, 3'd2, IN_POS_W'(1100 * 256), IN_POS_W'(300 * 256),
             IN_POS_W'(1090 * 256), IN_POS_W'(300 * 256));
        send(KIND_LOAD, 3'd3, IN_POS_W'(500 * 256), IN_POS_W'(700 * 256),
             IN_POS_W'(500 * 256), IN_POS_W'(690 * 256));
        send(KIND_LOAD, 3'd4, IN_POS_W'(20 * 256), IN_POS_W'(20 * 256),
             IN_POS_W'(25 * 256), IN_POS_W'(25 * 256));
        send(KIND_LOAD, 3'd5, IN_POS_W'(500 * 256 + 128), IN_POS_W'(300 * 256 + 200),
             IN_POS_W'(500 * 256 + 128), IN_POS_W'(300 * 256 + 200));
        send(KIND_LOAD, 3'd6, IN_POS_W'(-300), IN_POS_W'(-1), IN_POS_W'(-300), IN_POS_W'(-1));
        send(KIND_LOAD, 3'd7, IN_POS_W'(1029 * 256), IN_POS_W'(669 * 256),
             IN_POS_W'(1029 * 256 - 1), IN_POS_W'(669 * 256 + 1));
        tick();
        tick();

        // Count of zero, count beyond the table
        drain();
        write_all(int'(FRICTION_RST), int'(BOUNCE_RST), int'(GRAVITY_RST), int'(NEAR_RST),
                  int'(RIGHT_RST), int'(BOTTOM_RST), int'(RADIUS_RST), 0);
        tick();
        drain();
        write_all(int'(FRICTION_RST), int'(BOUNCE_RST), int'(GRAVITY_RST), int'(NEAR_RST),
                  int'(RIGHT_RST), int'(BOTTOM_RST), int'(RADIUS_RST), 15);
        tick();

        // Register extremes both ways, walls crossed over
        drain();
        write_all(65535, 0, 4095, 0, 2047, 2047, 0, TABLE_DEPTH);
        tick();
        drain();
        write_all(0, 65535, -4096, 2047, 0, 0, 255, 1);
        tick();

        // Random phases, each under its own settings
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            pick_config();
            no_gaps = (phase % 3 == 2);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ((phase == 0 && k == 20) || $urandom_range(0, 49) == 0)
                    hold_for_results();
                if ($urandom_range(0, 2) == 0)
                    random_load();
                else
                    tick();
            end
        end

        start <= 1'b0;
        for (w = 0; w < 4000 && sb.pending() != 0; w++)
            @(posedge clk);
        repeat (40) @(posedge clk);
        sb.flag_leftover();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
